@@ hw/rtl/dzpv_pkg.sv @@
package dzpv_pkg;

   // Field widths.
   localparam int POS_W      = 32;
   localparam int FRAC_W     = 16;
   localparam int GAIN_W     = 24;
   localparam int SPEED_W    = 31;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Derived datapath widths.
   localparam int THR_W  = POS_W + FRAC_W + 1;
   localparam int DIST_W = POS_W + 1;
   localparam int PROD_W = DIST_W + GAIN_W;
   localparam int MAG_W  = PROD_W - FRAC_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLED        = 3'd0,
      REG_DIRECTION_MODE = 3'd1,
      REG_REFERENCE      = 3'd2,
      REG_DEADZONE       = 3'd3,
      REG_GAIN           = 3'd4,
      REG_MAX_SPEED      = 3'd5
   } reg_index_type;

   typedef enum logic [MODE_W-1:0] {
      DIR_POSITIVE = 2'd0,
      DIR_NEGATIVE = 2'd1,
      DIR_BOTH     = 2'd2
   } dir_mode_type;

   localparam logic [FRAC_W-1:0]  RST_DEADZONE  = 16'd6554;
   localparam logic [GAIN_W-1:0]  RST_GAIN      = 24'd65536;
   localparam logic [SPEED_W-1:0] RST_MAX_SPEED = 31'd65536;

   typedef struct packed {
      logic                     enabled;
      logic [MODE_W-1:0]        direction_mode;
      logic signed [POS_W-1:0]  reference_position;
      logic [FRAC_W-1:0]        deadzone_fraction;
      logic [GAIN_W-1:0]        velocity_gain;
      logic [SPEED_W-1:0]       max_speed;
   } cfg_type;

   // Deadzone edges on the position scaled by 2^16.
   typedef struct packed {
      logic signed [THR_W-1:0] upper;
      logic signed [THR_W-1:0] lower;
   } thresh_type;

   // Handoff from the pipeline to the result stage.
   typedef struct packed {
      logic             valid;
      logic             pos;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } steer_type;

endpackage

@@ hw/rtl/dzpv_intf.sv @@
interface dzpv_req_if;
   import dzpv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] measured_position;
   modport source (output valid, output measured_position, input ready);
   modport sink (input valid, input measured_position, output ready);
endinterface

interface dzpv_rsp_if;
   import dzpv_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] velocity_out;
   logic                    start_flag;
   logic                    finished_flag;
   modport source (output valid, output velocity_out, output start_flag,
                   output finished_flag, input ready);
   modport sink (input valid, input velocity_out, input start_flag,
                 input finished_flag, output ready);
endinterface

interface dzpv_csr_if;
   import dzpv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dzpv_csr.sv @@
module dzpv_csr (
   input  logic             clock,
   input  logic             reset,
   dzpv_csr_if.sink         csr_chan,
   output dzpv_pkg::cfg_type cfg
);
   import dzpv_pkg::*;

   cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled            <= 1'b0;
         cfg_ff.direction_mode     <= DIR_BOTH;
         cfg_ff.reference_position <= '0;
         cfg_ff.deadzone_fraction  <= RST_DEADZONE;
         cfg_ff.velocity_gain      <= RST_GAIN;
         cfg_ff.max_speed          <= RST_MAX_SPEED;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_ENABLED:        cfg_ff.enabled <= csr_chan.data[0];
            REG_DIRECTION_MODE: cfg_ff.direction_mode <= csr_chan.data[MODE_W-1:0];
            REG_REFERENCE:      cfg_ff.reference_position <= csr_chan.data[POS_W-1:0];
            REG_DEADZONE:       cfg_ff.deadzone_fraction <= csr_chan.data[FRAC_W-1:0];
            REG_GAIN:           cfg_ff.velocity_gain <= csr_chan.data[GAIN_W-1:0];
            REG_MAX_SPEED:      cfg_ff.max_speed <= csr_chan.data[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/dzpv_thresh.sv @@
module dzpv_thresh (
   input  logic                 clock,
   input  dzpv_pkg::cfg_type    cfg,
   output dzpv_pkg::thresh_type thr
);
   import dzpv_pkg::*;

   logic signed [THR_W-1:0] ref_prod;
   logic signed [THR_W-1:0] ref_shift;
   logic signed [THR_W-1:0] edge_sum;
   logic signed [THR_W-1:0] edge_diff;
   logic signed [THR_W-1:0] dz_abs;
   logic                    ref_zero;
   logic                    ref_neg;
   thresh_type              thr_in;
   thresh_type              thr_ff;

   // r*(1 +/- d) in Q32 terms is (r << 16) +/- r*d.
   assign ref_prod  = cfg.reference_position * $signed({1'b0, cfg.deadzone_fraction});
   assign ref_shift = THR_W'($signed({cfg.reference_position, FRAC_W'(0)}));
   assign edge_sum  = ref_shift + ref_prod;
   assign edge_diff = ref_shift - ref_prod;
   assign dz_abs    = THR_W'({cfg.deadzone_fraction, FRAC_W'(0)});
   assign ref_zero  = (cfg.reference_position == '0);
   assign ref_neg   = cfg.reference_position[POS_W-1];

   always_comb begin
      if (ref_zero) begin
         thr_in.upper = dz_abs;
         thr_in.lower = -dz_abs;
      end else if (ref_neg) begin
         thr_in.upper = edge_diff;
         thr_in.lower = edge_sum;
      end else begin
         thr_in.upper = edge_sum;
         thr_in.lower = edge_diff;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff <= thr_in;
   end

   assign thr = thr_ff;

endmodule

@@ hw/rtl/dzpv_pipe.sv @@
module dzpv_pipe (
   input  logic                 clock,
   input  logic                 reset,
   dzpv_req_if.sink             req_chan,
   input  dzpv_pkg::cfg_type    cfg,
   input  dzpv_pkg::thresh_type thr,
   output dzpv_pkg::steer_type  steer,
   input  logic                 steer_ready
);
   import dzpv_pkg::*;

   logic                    v1_ff;
   logic signed [POS_W-1:0] pos1_ff;
   logic                    v2_ff;
   logic signed [POS_W-1:0] pos2_ff;
   logic [DIST_W-1:0]       dist2_ff;
   steer_type               steer_ff;
   steer_type               steer_in;

   logic                    ready1;
   logic                    ready2;
   logic                    ready3;
   logic signed [DIST_W-1:0] gap;
   logic [DIST_W-1:0]       dist_in;
   logic signed [THR_W-1:0] pos_scaled;
   logic [PROD_W-1:0]       prod;
   logic                    pos_ok;
   logic                    neg_ok;

   // Each stage moves when it is empty or the next one moves.
   assign ready3 = !steer_ff.valid || steer_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_chan.ready = ready1;

   // Stage 1 to 2: exact distance from the reference.
   assign gap     = DIST_W'(cfg.reference_position) - DIST_W'(pos1_ff);
   assign dist_in = gap[DIST_W-1] ? -gap : gap;

   // Stage 2 to 3: deadzone tests and the gain multiply.
   assign pos_scaled = {pos2_ff[POS_W-1], pos2_ff, FRAC_W'(0)};
   assign pos_ok     = (cfg.direction_mode != DIR_NEGATIVE);
   assign neg_ok     = (cfg.direction_mode != DIR_POSITIVE);
   assign prod       = dist2_ff * cfg.velocity_gain;

   always_comb begin
      steer_in.valid = v2_ff;
      steer_in.pos   = pos_ok && (pos_scaled > thr.upper);
      steer_in.neg   = neg_ok && (pos_scaled < thr.lower);
      steer_in.mag   = prod[PROD_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         steer_ff.valid <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_chan.valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            steer_ff.valid <= steer_in.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_chan.valid) begin
         pos1_ff <= req_chan.measured_position;
      end
      if (ready2 && v1_ff) begin
         pos2_ff  <= pos1_ff;
         dist2_ff <= dist_in;
      end
      if (ready3 && v2_ff) begin
         steer_ff.pos <= steer_in.pos;
         steer_ff.neg <= steer_in.neg;
         steer_ff.mag <= steer_in.mag;
      end
   end

   assign steer = steer_ff;

endmodule

@@ hw/rtl/dzpv_resolve.sv @@
module dzpv_resolve (
   input  logic                clock,
   input  logic                reset,
   input  dzpv_pkg::cfg_type   cfg,
   input  dzpv_pkg::steer_type steer,
   output logic                steer_ready,
   dzpv_rsp_if.source          rsp_chan
);
   import dzpv_pkg::*;

   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] vel_ff;
   logic                    start_ff;
   logic                    fin_ff;
   logic                    was_moving_ff;

   logic                    out_ready;
   logic                    take;
   logic                    over;
   logic [SPEED_W-1:0]      mag_clamped;
   logic                    moving;
   logic [POS_W-1:0]        mag_ext;
   logic signed [POS_W-1:0] vel_in;
   logic                    start_in;
   logic                    fin_in;

   assign out_ready   = !rsp_valid_ff || rsp_chan.ready;
   assign steer_ready = out_ready;
   assign take        = steer.valid && out_ready;

   assign over        = steer.mag > MAG_W'(cfg.max_speed);
   assign mag_clamped = over ? cfg.max_speed : steer.mag[SPEED_W-1:0];
   assign mag_ext     = POS_W'(mag_clamped);

   // A disabled block never moves, which also makes finished follow was_moving.
   assign moving   = cfg.enabled && (steer.pos || steer.neg) && (mag_clamped != '0);
   assign vel_in   = !moving ? '0 : (steer.neg ? -mag_ext : mag_ext);
   assign start_in = moving && !was_moving_ff;
   assign fin_in   = !moving && was_moving_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         was_moving_ff <= 1'b0;
      end else begin
         if (out_ready) begin
            rsp_valid_ff <= steer.valid;
         end
         if (take) begin
            was_moving_ff <= moving;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         vel_ff   <= vel_in;
         start_ff <= start_in;
         fin_ff   <= fin_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.velocity_out  = vel_ff;
   assign rsp_chan.start_flag    = start_ff;
   assign rsp_chan.finished_flag = fin_ff;

endmodule

@@ hw/rtl/deadzone_proportional_velocity.sv @@
// Proportional velocity controller with a deadzone. Each request carries one
// signed Q16.16 position sample; the block answers each with exactly one
// result holding a signed Q16.16 velocity, a start flag and a finished flag,
// in request order. The block takes one request per clock while the result side
// keeps up; the datapath registers the input sample, then the distance, then
// the deadzone compare together with the 33 by 24 bit gain multiply, then the
// clamp, sign and flag logic that feeds the output register. Stalls on the
// result side fill empty stages first, so requests keep flowing until the
// pipeline is full. The deadzone edges are products of the reference and the
// deadzone fraction; they are computed from the configuration registers and
// held in a register of their own, so they follow a configuration write
// through the configuration register and then the edge register. Configuration
// writes are always accepted and should only be issued while no request is in
// flight; indexes beyond the last register are ignored. When the block is
// disabled every result has zero velocity and a finished flag if the previous
// result was moving.
module deadzone_proportional_velocity (
   input  logic       clock,
   input  logic       reset,
   dzpv_req_if.sink   req_chan,
   dzpv_rsp_if.source rsp_chan,
   dzpv_csr_if.sink   csr_chan
);
   import dzpv_pkg::*;

   cfg_type    cfg;
   thresh_type thr;
   steer_type  steer;
   logic       steer_ready;

   // Configuration registers.
   dzpv_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Deadzone edges derived from the reference and deadzone fraction.
   dzpv_thresh u_thresh (
      .clock (clock),
      .cfg   (cfg),
      .thr   (thr)
   );

   // Input register, distance, deadzone tests and gain multiply.
   dzpv_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg),
      .thr         (thr),
      .steer       (steer),
      .steer_ready (steer_ready)
   );

   // Clamp, sign, motion flags and the output register.
   dzpv_resolve u_resolve (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .steer       (steer),
      .steer_ready (steer_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

@@ hw/rtl/dzpv_checker.sv @@
module dzpv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dzpv_pkg::POS_W-1:0] velocity_out,
   input logic                              start_flag,
   input logic                              finished_flag
);
   import dzpv_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(velocity_out)
         && $stable(start_flag) && $stable(finished_flag))
      else $error("stalled result changed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(start_flag && finished_flag))
      else $error("start and finished raised together");

   a_start_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start_flag |-> velocity_out != '0)
      else $error("start raised with zero velocity");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished_flag |-> velocity_out == '0)
      else $error("finished raised with nonzero velocity");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind deadzone_proportional_velocity dzpv_checker u_dzpv_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .velocity_out  (rsp_chan.velocity_out),
   .start_flag    (rsp_chan.start_flag),
   .finished_flag (rsp_chan.finished_flag)
);

@@ test/deadzone_proportional_velocity_tb.sv @@
module deadzone_proportional_velocity_tb;
   import dzpv_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 1850;
   // The drain below covers the register stages of the datapath with margin.
   localparam int DRAIN_CYCLES  = 10;
   // The deadzone edge register follows a write through the configuration register.
   localparam int SETTLE_CYCLES = 2;
   localparam int IDLE_LIMIT    = 1000;
   localparam int MAX_REPORTS   = 60;

   // Register indexes past the last register; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   // The unnamed fourth direction code, which must behave like both directions.
   localparam logic [MODE_W-1:0] DIR_MODE_SPARE = 2'd3;

   typedef struct {
      logic signed [POS_W-1:0] velocity;
      logic                    start;
      logic                    finished;
   } motion_result_type;

   // Shapes of position samples relative to the current reference.
   typedef enum {
      POS_ANY, POS_NEAR_REST, POS_UPPER_EDGE, POS_LOWER_EDGE, POS_EXTREME, POS_AT_REST
   } position_kind_type;

   // Receiver behavior patterns, switched at random.
   typedef enum {
      RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_LONG_STALL
   } rx_pattern_type;

   // Mirrors the controller: its own copy of the registers and of the motion flag,
   // and the queue of velocity results still owed by the block.
   class motion_scoreboard;
      logic                    enabled;
      logic [MODE_W-1:0]       mode;
      logic signed [POS_W-1:0] rest_position;
      logic [FRAC_W-1:0]       deadzone;
      logic [GAIN_W-1:0]       gain;
      logic [SPEED_W-1:0]      speed_limit;
      logic                    was_moving;
      motion_result_type       owed_q[$];
      int                      errors;

      function new();
         enabled       = 1'b0;
         mode          = DIR_BOTH;
         rest_position = '0;
         deadzone      = RST_DEADZONE;
         gain          = RST_GAIN;
         speed_limit   = RST_MAX_SPEED;
         was_moving    = 1'b0;
         errors        = 0;
      endfunction

      function void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_ENABLED:        enabled       = data[0];
            REG_DIRECTION_MODE: mode          = data[MODE_W-1:0];
            REG_REFERENCE:      rest_position = data[POS_W-1:0];
            REG_DEADZONE:       deadzone      = data[FRAC_W-1:0];
            REG_GAIN:           gain          = data[GAIN_W-1:0];
            REG_MAX_SPEED:      speed_limit   = data[SPEED_W-1:0];
            default: ;
         endcase
      endfunction

      function motion_result_type velocity_for(logic signed [POS_W-1:0] pos);
         motion_result_type  res;
         longint             r;
         longint             p;
         longint             d;
         longint             distance;
         longint             mag;
         int                 dir;
         logic [POS_W-1:0]   vel;
         r   = rest_position;
         p   = pos;
         d   = longint'(deadzone);
         dir = 0;
         vel = '0;
         if (!enabled) begin
            res.velocity = '0;
            res.start    = 1'b0;
            res.finished = was_moving;
            was_moving   = 1'b0;
            return res;
         end
         // Edges are compared on the sample scaled by 2^16, so no rounding enters.
         if (mode != DIR_NEGATIVE) begin
            if (r < 0 && p * 65536 > r * (65536 - d))
               dir = 1;
            else if (r > 0 && p * 65536 > r * (65536 + d))
               dir = 1;
            else if (r == 0 && p > d)
               dir = 1;
         end
         if (mode != DIR_POSITIVE) begin
            if (r < 0 && p * 65536 < r * (65536 + d))
               dir = -1;
            else if (r > 0 && p * 65536 < r * (65536 - d))
               dir = -1;
            else if (r == 0 && p < -d)
               dir = -1;
         end
         if (dir != 0) begin
            distance = (r >= p) ? r - p : p - r;
            mag      = (distance * longint'(gain)) >>> 16;
            if (mag > longint'(speed_limit))
               mag = longint'(speed_limit);
            vel = mag[POS_W-1:0];
            if (dir < 0)
               vel = -vel;
         end
         res.velocity = vel;
         res.start    = !was_moving && (vel != 0);
         res.finished = was_moving && (vel == 0);
         was_moving   = (vel != 0);
         return res;
      endfunction

      function void note_request(logic signed [POS_W-1:0] pos);
         owed_q.push_back(velocity_for(pos));
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void report(string field, longint want, longint got);
         if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      endfunction

      function void check_result(logic signed [POS_W-1:0] vel, logic start, logic finished);
         motion_result_type want;
         if (owed_q.size() == 0) begin
            report("unexpected result velocity", 0, vel);
            return;
         end
         want = owed_q.pop_front();
         if (vel !== want.velocity)
            report("velocity_out", want.velocity, vel);
         if (start !== want.start)
            report("start_flag", want.start, start);
         if (finished !== want.finished)
            report("finished_flag", want.finished, finished);
      endfunction
   endclass

   logic clock;
   logic reset;

   dzpv_req_if req_if ();
   dzpv_rsp_if rsp_if ();
   dzpv_csr_if csr_if ();

   deadzone_proportional_velocity dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   motion_scoreboard board;
   int               idle_cycles;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The receiver keeps its own stall pattern, independent of the sender, so that
   // back pressure lands on every stage of the pipeline. It changes at the falling
   // edge like every other input of the block.
   initial begin : receiver
      rx_pattern_type pattern;
      int             pattern_left;
      int             stall_left;
      rsp_if.ready = 1'b0;
      pattern      = RX_STREAM;
      pattern_left = 0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (pattern_left == 0) begin
            pattern      = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 200);
         end
         pattern_left--;
         case (pattern)
            RX_STREAM: rsp_if.ready <= 1'b1;
            RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_left > 0) begin
                  rsp_if.ready <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_if.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0)
                     stall_left = $urandom_range(1, 30);
               end
            end
         endcase
      end
   end

   // All handshakes are observed at the rising edge. A configuration write updates
   // the mirrored registers, an accepted request queues its predicted result, and
   // an accepted result is checked against the oldest one queued. The watchdog
   // counts edges at which none of the three channels moved anything.
   always @(posedge clock) begin : monitor
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            board.apply_register(csr_if.index, csr_if.data);
            moved = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            board.note_request(req_if.measured_position);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_result(rsp_if.velocity_out, rsp_if.start_flag, rsp_if.finished_flag);
            moved = 1'b1;
         end
         if (moved)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("deadzone_proportional_velocity_tb failed");
            $finish;
         end
      end
   end

   // Presents one request and holds it until the block takes it. Valid stays high
   // on return so that back-to-back requests form a burst.
   task automatic send_request(input logic signed [POS_W-1:0] pos);
      @(negedge clock);
      req_if.valid             <= 1'b1;
      req_if.measured_position <= pos;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drops valid for a gap of the given number of cycles.
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Holds off the sender until every owed result has been taken.
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Brings the block to idle so that its registers may be written.
   task automatic quiesce();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Fills the bits above a register's width with noise; the block must drop them.
   function automatic logic [CSR_DATA_W-1:0] with_junk(input logic [CSR_DATA_W-1:0] value,
                                                       input int width);
      logic [CSR_DATA_W-1:0] keep;
      if (width >= CSR_DATA_W)
         return value;
      keep = (32'h1 << width) - 1;
      return ($urandom & ~keep) | (value & keep);
   endfunction

   // Writes every register while the block is idle, then lets the edge register
   // catch up before the next request goes out.
   task automatic program_controller(input logic en, input logic [MODE_W-1:0] mode,
                                     input logic [POS_W-1:0] rest_val,
                                     input logic [FRAC_W-1:0] dz,
                                     input logic [GAIN_W-1:0] g,
                                     input logic [SPEED_W-1:0] limit);
      quiesce();
      set_register(REG_ENABLED, with_junk(32'(en), 1));
      set_register(REG_DIRECTION_MODE, with_junk(32'(mode), MODE_W));
      set_register(REG_REFERENCE, rest_val);
      set_register(REG_DEADZONE, with_junk(32'(dz), FRAC_W));
      set_register(REG_GAIN, with_junk(32'(g), GAIN_W));
      set_register(REG_MAX_SPEED, with_junk(32'(limit), SPEED_W));
      if ($urandom_range(0, 3) == 0)
         set_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Picks a random setting, with the extremes of each register well represented.
   task automatic random_setting();
      logic                en;
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    rest_val;
      logic [FRAC_W-1:0]   dz;
      logic [GAIN_W-1:0]   g;
      logic [SPEED_W-1:0]  limit;
      en   = ($urandom_range(0, 9) != 0);
      mode = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: rest_val = '0;
         1: rest_val = $urandom;
         2: rest_val = int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
         3: rest_val = 32'h7FFF_FFFF;
         4: rest_val = 32'h8000_0000;
         default: rest_val = $urandom_range(0, 1) ? int'($urandom_range(1, 2 ** 18))
                                                 : -int'($urandom_range(1, 2 ** 18));
      endcase
      case ($urandom_range(0, 3))
         0: dz = '0;
         1: dz = 16'hFFFF;
         default: dz = FRAC_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: g = '0;
         1: g = 24'hFF_FFFF;
         2: g = 24'd65536;
         3: g = GAIN_W'($urandom_range(1, 1023));
         default: g = GAIN_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: limit = '0;
         1: limit = 31'h7FFF_FFFF;
         2: limit = SPEED_W'($urandom_range(1, 2 ** 20));
         default: limit = SPEED_W'($urandom);
      endcase
      program_controller(en, mode, rest_val, dz, g, limit);
   endtask

   function automatic logic [POS_W-1:0] saturate_position(input longint v);
      if (v > 64'sd2147483647)
         return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648)
         return 32'h8000_0000;
      return v[POS_W-1:0];
   endfunction

   // One deadzone edge in raw Q16.16 units for the current setting.
   function automatic longint deadzone_edge(input bit upper);
      longint r;
      longint d;
      r = board.rest_position;
      d = longint'(board.deadzone);
      if (r == 0)
         return upper ? d : -d;
      if ((r > 0) == upper)
         return (r * (65536 + d)) / 65536;
      return (r * (65536 - d)) / 65536;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input position_kind_type kind);
      longint r;
      r = board.rest_position;
      case (kind)
         POS_NEAR_REST:
            return saturate_position(r + longint'($urandom_range(0, 2 ** 17)) - 2 ** 16);
         POS_UPPER_EDGE:
            return saturate_position(deadzone_edge(1'b1) + longint'($urandom_range(0, 8)) - 4);
         POS_LOWER_EDGE:
            return saturate_position(deadzone_edge(1'b0) + longint'($urandom_range(0, 8)) - 4);
         POS_EXTREME:
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return '0;
               default: return '1;
            endcase
         POS_AT_REST:
            return board.rest_position;
         default:
            return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      position_kind_type kind;
      int                sent;
      int                phase_items;
      int                seg_left;
      int                burst_left;
      bit                paused;

      reset                    = 1'b1;
      req_if.valid             = 1'b0;
      req_if.measured_position = '0;
      csr_if.valid             = 1'b0;
      csr_if.index             = '0;
      csr_if.data              = '0;
      idle_cycles              = 0;
      board                    = new();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Writes past the last register must leave the reset setting alone, which the
      // two disabled requests that follow would expose.
      set_register(REG_SPARE_LO, $urandom);
      set_register(REG_SPARE_HI, $urandom);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sh8000_0000);

      // Zero reference: the deadzone is an absolute band of raw Q16.16 units.
      // Walk through both edges and both saturating extremes.
      program_controller(1'b1, DIR_BOTH, '0, RST_DEADZONE, RST_GAIN, RST_MAX_SPEED);
      send_request('0);
      send_request(32'sd6555);
      send_request(-32'sd6555);
      send_request(32'sd6554);
      send_request(-32'sd6554);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sh8000_0000);
      send_request('0);

      // Positive reference, widest deadzone, largest gain and speed, positive only.
      program_controller(1'b1, DIR_POSITIVE, 32'h0001_0000, 16'hFFFF, 24'hFF_FFFF,
                         31'h7FFF_FFFF);
      send_request(32'sh7FFF_FFFF);
      send_request(32'sh8000_0000);
      send_request(32'sh0002_0000);

      // Negative reference, negative only: the positive side must stay blocked.
      program_controller(1'b1, DIR_NEGATIVE, 32'hFFFF_0000, 16'hFFFF, 24'd1,
                         31'h7FFF_FFFF);
      send_request(32'sh8000_0000);
      send_request(32'sh7FFF_FFFF);
      send_request(-32'sd131072);

      // The spare direction code acts as both directions. With zero gain the sample
      // is past the deadzone yet the velocity is zero, which must read as rest.
      program_controller(1'b1, DIR_MODE_SPARE, 32'h0000_8000, '0, '0, 31'h7FFF_FFFF);
      send_request(32'sh7FFF_FFFF);

      // Gain of one raw LSB: a distance just under one unit truncates to zero velocity.
      program_controller(1'b1, DIR_MODE_SPARE, 32'h0000_8000, '0, 24'd1, 31'h7FFF_FFFF);
      send_request(32'sh0001_7FFF);
      send_request(32'sh0001_8000);

      // Disabling while in motion reports the finish and clears the motion flag.
      program_controller(1'b0, DIR_BOTH, 32'h0000_8000, '0, 24'd1, 31'h7FFF_FFFF);
      send_request('0);

      // Random phases, each under its own setting. Within a phase the samples come
      // in short runs of one shape, so that rest and motion alternate and the start
      // and finish flags get exercised. The sender works in bursts with gaps.
      sent       = 0;
      burst_left = $urandom_range(1, 24);
      paused     = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         random_setting();
         phase_items = $urandom_range(20, 120);
         seg_left    = 0;
         repeat (phase_items) begin
            if (seg_left == 0) begin
               kind     = position_kind_type'($urandom_range(0, 5));
               seg_left = $urandom_range(1, 6);
            end
            seg_left--;
            if (burst_left == 0) begin
               if ($urandom_range(0, 2) != 0)
                  pause_sender($urandom_range(1, 12));
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            // Once, halfway through, the sender waits for the pipeline to empty.
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
               wait_for_results();
               paused = 1'b1;
            end
            send_request(pick_position(kind));
            sent++;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("deadzone_proportional_velocity_tb passed");
      else
         $display("deadzone_proportional_velocity_tb failed");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/dzpv_pkg.sv
hw/rtl/dzpv_intf.sv
hw/rtl/dzpv_csr.sv
hw/rtl/dzpv_thresh.sv
hw/rtl/dzpv_pipe.sv
hw/rtl/dzpv_resolve.sv
hw/rtl/deadzone_proportional_velocity.sv
hw/rtl/dzpv_checker.sv
test/deadzone_proportional_velocity_tb.sv
